// ===== src/pcls_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcls_pkg
// Shared types, tag codes and helpers for the per-class latency statistics.
// ----------------------------------------------------------------------------
package pcls_pkg;

	localparam int ACC_WIDTH_DEF   = 64;
	localparam int NUM_CLASSES_DEF = 6;

	localparam int CNT_W      = 64;
	localparam int TIME_W     = 32;
	localparam int TAG_W      = 8;
	localparam int AVG_W      = 16;
	localparam int CLS_W      = 3;
	localparam int IN_DATA_W  = 40;   // tag + elapsed, padded to whole bytes
	localparam int OUT_DATA_W = 144;  // count + all-time count + average

	localparam logic [AVG_W-1:0] AVG_MAX = 16'hFFFF;

	// request tags
	localparam logic [TAG_W-1:0] TAG_BIND   = 8'h60;
	localparam logic [TAG_W-1:0] TAG_UNBIND = 8'h42;
	localparam logic [TAG_W-1:0] TAG_SEARCH = 8'h63;
	localparam logic [TAG_W-1:0] TAG_MODIFY = 8'h66;
	localparam logic [TAG_W-1:0] TAG_ADD    = 8'h68;
	localparam logic [TAG_W-1:0] TAG_DELETE = 8'h4A;

	// class numbers
	localparam logic [CLS_W-1:0] CLS_BIND   = 3'd0;
	localparam logic [CLS_W-1:0] CLS_UNBIND = 3'd1;
	localparam logic [CLS_W-1:0] CLS_SEARCH = 3'd2;
	localparam logic [CLS_W-1:0] CLS_MODIFY = 3'd3;
	localparam logic [CLS_W-1:0] CLS_ADD    = 3'd4;
	localparam logic [CLS_W-1:0] CLS_DELETE = 3'd5;

	typedef struct packed {
		logic             hit;
		logic [CLS_W-1:0] cls;
	} pcls_class_t;

	// one queued transaction, already classified
	typedef struct packed {
		logic              record;
		logic              hit;
		logic [CLS_W-1:0]  cls;
		logic [TIME_W-1:0] elapsed;   // zero already replaced by one
	} pcls_item_t;

	typedef struct packed {
		logic busy;
		logic done;
	} pcls_div_stat_t;

	function automatic pcls_class_t pcls_tag_class(input logic [TAG_W-1:0] tag);
		pcls_class_t r;
		r.hit = 1'b1;
		r.cls = CLS_BIND;
		case (tag)
			TAG_BIND:   r.cls = CLS_BIND;
			TAG_UNBIND: r.cls = CLS_UNBIND;
			TAG_SEARCH: r.cls = CLS_SEARCH;
			TAG_MODIFY: r.cls = CLS_MODIFY;
			TAG_ADD:    r.cls = CLS_ADD;
			TAG_DELETE: r.cls = CLS_DELETE;
			default:    r.hit = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/pcls_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcls_front
// Accepts request transactions, decodes the tag into a class and holds the
// classified items in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module pcls_front #(
	parameter int NUM_CLASSES = pcls_pkg::NUM_CLASSES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [pcls_pkg::IN_DATA_W-1:0] s_tdata,   // op_tag[7:0], elapsed_ms[39:8]
	input  logic                           s_tuser,   // req_type
	output logic                           item_valid,
	input  logic                           item_ready,
	output pcls_pkg::pcls_item_t           item
);
	import pcls_pkg::*;

	pcls_class_t cl;
	pcls_item_t  new_item;
	pcls_item_t  fifo_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        push;
	logic        pop;
	logic [TIME_W-1:0] t_in;

	assign t_in = s_tdata[TAG_W +: TIME_W];
	assign cl   = pcls_tag_class(s_tdata[TAG_W-1:0]);

	always_comb begin
		new_item.record  = ~s_tuser;
		new_item.hit     = cl.hit && (5'(cl.cls) < 5'(NUM_CLASSES));
		new_item.cls     = cl.cls;
		new_item.elapsed = (t_in == '0) ? TIME_W'(1) : t_in;
	end

	assign s_tready   = (cnt_q != 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = fifo_q[rd_ptr_q];
	assign push       = s_tvalid && s_tready;
	assign pop        = item_valid && item_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("queue occupancy out of range");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with occupancy");

endmodule

// ===== src/pcls_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcls_div
// Restoring bit-serial divider, one quotient bit per cycle, quotient
// saturated to 16 bits.
// ----------------------------------------------------------------------------
module pcls_div #(
	parameter int ACC_WIDTH = pcls_pkg::ACC_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ACC_WIDTH-1:0]       dividend,
	input  logic [pcls_pkg::CNT_W-1:0] divisor,
	output pcls_pkg::pcls_div_stat_t   stat,
	output logic [pcls_pkg::AVG_W-1:0] quotient
);
	import pcls_pkg::*;

	localparam int STEP_W = $clog2(ACC_WIDTH + 1);

	logic [CNT_W-1:0]     rem_q;
	logic [ACC_WIDTH-1:0] quo_q;
	logic [CNT_W-1:0]     div_q;
	logic [STEP_W-1:0]    step_q;
	logic                 busy_q;
	logic [CNT_W:0]       trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[ACC_WIDTH-1]};
	assign fits  = (trial >= {1'b0, div_q});

	assign stat.busy = busy_q;
	assign stat.done = busy_q && (step_q == '0);
	assign quotient  = (quo_q > ACC_WIDTH'(AVG_MAX)) ? AVG_MAX : quo_q[AVG_W-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q && step_q != '0) begin
			rem_q <= fits ? CNT_W'(trial - {1'b0, div_q}) : trial[CNT_W-1:0];
			quo_q <= {quo_q[ACC_WIDTH-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(ACC_WIDTH);
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q - STEP_W'(1);
			end
		end
	end

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule

// ===== src/pcls_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcls_back
// Applies queued items to the per-class counters, runs the average through
// the serial divider and holds the result in the output register.
// ----------------------------------------------------------------------------
module pcls_back #(
	parameter int ACC_WIDTH   = pcls_pkg::ACC_WIDTH_DEF,
	parameter int NUM_CLASSES = pcls_pkg::NUM_CLASSES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  pcls_pkg::pcls_item_t            item,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pcls_pkg::OUT_DATA_W-1:0] m_tdata,  // op_count[63:0],
	                                                  // all_time_count[127:64],
	                                                  // avg_ms[143:128]
	output logic                            m_tuser   // recognized
);
	import pcls_pkg::*;

	localparam int CIW   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int SUM_W = ((ACC_WIDTH > TIME_W) ? ACC_WIDTH : TIME_W) + 1;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_OUT  = 2'd2;

	localparam logic [ACC_WIDTH-1:0] ACC_MASK = {ACC_WIDTH{1'b1}};

	logic [ACC_WIDTH-1:0] accum_q [NUM_CLASSES];
	logic [CNT_W-1:0]     count_q [NUM_CLASSES];
	logic [CNT_W-1:0]     ever_q  [NUM_CLASSES];

	logic [1:0]           st_q;
	logic                 res_hit_q;
	logic [CNT_W-1:0]     res_cnt_q;
	logic [CNT_W-1:0]     res_ever_q;
	logic [AVG_W-1:0]     res_avg_q;

	logic                 m_tvalid_q;
	logic                 out_hit_q;
	logic [CNT_W-1:0]     out_cnt_q;
	logic [CNT_W-1:0]     out_ever_q;
	logic [AVG_W-1:0]     out_avg_q;

	logic [CIW-1:0]       idx;
	logic [ACC_WIDTH-1:0] acc_rd;
	logic [SUM_W-1:0]     sum;
	logic [SUM_W-1:0]     t_ext;
	logic [SUM_W-1:0]     mask_ext;
	logic                 wrap;
	logic                 upd;
	logic [ACC_WIDTH-1:0] new_acc;
	logic [CNT_W-1:0]     new_cnt;
	logic [CNT_W-1:0]     new_ever;
	logic                 take;
	logic                 div_start;
	logic                 out_load;
	pcls_div_stat_t       div_stat;
	logic [AVG_W-1:0]     div_quo;

	assign idx      = CIW'(item.cls);
	assign acc_rd   = accum_q[idx];
	assign t_ext    = SUM_W'(item.elapsed);
	assign mask_ext = SUM_W'(ACC_MASK);
	assign sum      = SUM_W'(acc_rd) + t_ext;
	assign wrap     = (sum > mask_ext);
	assign upd      = item.hit && item.record;

	always_comb begin
		new_acc  = acc_rd;
		new_cnt  = count_q[idx];
		new_ever = ever_q[idx];
		if (upd) begin
			new_ever = ever_q[idx] + CNT_W'(1);
			if (wrap) begin
				// accumulator restarts at this sample, count at one
				new_acc = (t_ext > mask_ext) ? ACC_MASK : t_ext[ACC_WIDTH-1:0];
				new_cnt = CNT_W'(1);
			end else begin
				new_acc = sum[ACC_WIDTH-1:0];
				new_cnt = count_q[idx] + CNT_W'(1);
			end
		end
	end

	assign item_ready = (st_q == ST_IDLE);
	assign take       = item_valid && item_ready;
	assign div_start  = take && item.hit && (new_cnt != '0);
	assign out_load   = (st_q == ST_OUT) && (!m_tvalid_q || m_tready);

	pcls_div #(
		.ACC_WIDTH (ACC_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (new_acc),
		.divisor  (new_cnt),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CLASSES; i++) begin
				accum_q[i] <= '0;
				count_q[i] <= '0;
				ever_q[i]  <= '0;
			end
		end else if (take && upd) begin
			accum_q[idx] <= new_acc;
			count_q[idx] <= new_cnt;
			ever_q[idx]  <= new_ever;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (take) begin
						st_q <= div_start ? ST_DIV : ST_OUT;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_hit_q  <= item.hit;
			res_cnt_q  <= item.hit ? new_cnt : '0;
			res_ever_q <= item.hit ? new_ever : '0;
			res_avg_q  <= '0;
		end else if (st_q == ST_DIV && div_stat.done) begin
			res_avg_q <= div_quo;
		end
		if (out_load) begin
			out_hit_q  <= res_hit_q;
			out_cnt_q  <= res_cnt_q;
			out_ever_q <= res_ever_q;
			out_avg_q  <= res_avg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = out_hit_q;
	assign m_tdata  = {out_avg_q, out_ever_q, out_cnt_q};

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (new_cnt != '0))
		else $error("divider started with zero count");

	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DIV) |-> div_stat.busy)
		else $error("waiting on an idle divider");

	a_out_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(st_q == ST_OUT))
		else $error("result presented outside the output state");

endmodule

// ===== src/per_class_latency_stats_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_class_latency_stats_top
// Per-class operation counts and average latency for six request classes.
// ----------------------------------------------------------------------------
// One result per request transaction. A request first updates the class
// counters, then runs through the bit-serial divider that forms the average,
// and the result then moves into the output register. Unrecognized tags and
// classes with a zero count skip the divider. A two-entry input queue keeps
// accepting transactions while the back end is busy, until it is full, and
// the output register lets the next request start while a result still
// waits on m_tready.
module per_class_latency_stats_top #(
	parameter int ACC_WIDTH   = pcls_pkg::ACC_WIDTH_DEF,
	parameter int NUM_CLASSES = pcls_pkg::NUM_CLASSES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pcls_pkg::IN_DATA_W-1:0]  s_tdata,   // op_tag[7:0], elapsed_ms[39:8]
	input  logic                            s_tuser,   // req_type
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pcls_pkg::OUT_DATA_W-1:0] m_tdata,   // op_count[63:0],
	                                                   // all_time_count[127:64],
	                                                   // avg_ms[143:128]
	output logic                            m_tuser    // recognized
);
	import pcls_pkg::*;

	logic       item_valid;
	logic       item_ready;
	pcls_item_t item;

	pcls_front #(
		.NUM_CLASSES (NUM_CLASSES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item)
	);

	pcls_back #(
		.ACC_WIDTH   (ACC_WIDTH),
		.NUM_CLASSES (NUM_CLASSES)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

// ===== bench/per_class_latency_stats_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_class_latency_stats_top_tb
// Self-checking bench for the per-class latency statistics block.
// ----------------------------------------------------------------------------
// A queue-fed driver sends record and query transactions. A local copy of
// the per-class counters and accumulators predicts each result, and the
// monitor compares every output field against the oldest prediction. Both
// sides throttle at random. A directed set comes first, then random traffic
// in three batches, with a full drain between batches and one batch that
// runs without any throttling.
// ----------------------------------------------------------------------------
module per_class_latency_stats_top_tb;

	import pcls_pkg::*;

	localparam int ACC_W      = ACC_WIDTH_DEF;
	localparam int N_CLS      = NUM_CLASSES_DEF;
	localparam logic [CNT_W-1:0] ACC_MASK = {CNT_W{1'b1}} >> (CNT_W - ACC_W);
	localparam int NO_CLASS   = -1;
	localparam logic REQ_RECORD = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;
	localparam int IDLE_PCT   = 23;
	localparam int WATCHDOG   = 5000;
	localparam int TAIL       = 200;

	typedef struct packed {
		logic              req_type;
		logic [TAG_W-1:0]  tag;
		logic [TIME_W-1:0] elapsed;
	} op_req_t;

	typedef struct packed {
		logic             recognized;
		logic [CNT_W-1:0] op_count;
		logic [CNT_W-1:0] all_time;
		logic [AVG_W-1:0] avg;
	} stats_result_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;   // op_tag[7:0], elapsed_ms[39:8]
	logic                  s_tuser  = 1'b0; // req_type
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // op_count[63:0], all_time_count[127:64],
	                                        // avg_ms[143:128]
	logic                  m_tuser;         // recognized

	per_class_latency_stats_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #2 clk = ~clk;

	op_req_t       pending_reqs[$];
	stats_result_t expected_stats[$];
	op_req_t       drv_req;
	op_req_t       sent_req;

	logic [CNT_W-1:0] time_sum  [N_CLS];
	logic [CNT_W-1:0] win_count [N_CLS];
	logic [CNT_W-1:0] life_count[N_CLS];

	int idle_pct = IDLE_PCT;
	int errors = 0;
	int stall_cycles = 0;
	int n_records = 0;
	int n_queries = 0;
	int n_unknown = 0;
	int n_results = 0;

	function automatic int tag_class(input logic [TAG_W-1:0] tag);
		int cls;
		case (tag)
			TAG_BIND:   cls = int'(CLS_BIND);
			TAG_UNBIND: cls = int'(CLS_UNBIND);
			TAG_SEARCH: cls = int'(CLS_SEARCH);
			TAG_MODIFY: cls = int'(CLS_MODIFY);
			TAG_ADD:    cls = int'(CLS_ADD);
			TAG_DELETE: cls = int'(CLS_DELETE);
			default:    cls = NO_CLASS;
		endcase
		if (cls >= N_CLS)
			cls = NO_CLASS;
		return cls;
	endfunction

	function automatic logic [TAG_W-1:0] class_tag(input int idx);
		case (idx)
			0:       return TAG_BIND;
			1:       return TAG_UNBIND;
			2:       return TAG_SEARCH;
			3:       return TAG_MODIFY;
			4:       return TAG_ADD;
			default: return TAG_DELETE;
		endcase
	endfunction

	// applies one transaction to the local counters, returns what the block reports
	function automatic stats_result_t stats_apply(input op_req_t r);
		stats_result_t    res;
		int               cls;
		logic [CNT_W-1:0] t;
		logic [CNT_W-1:0] acc;
		logic [CNT_W-1:0] q;
		res = '0;
		cls = tag_class(r.tag);
		if (cls == NO_CLASS)
			return res;
		if (r.req_type == REQ_RECORD) begin
			t = (r.elapsed == '0) ? 64'd1 : {{(CNT_W-TIME_W){1'b0}}, r.elapsed};
			acc = time_sum[cls] & ACC_MASK;
			life_count[cls] = life_count[cls] + 1;
			if (t > ACC_MASK - acc) begin
				// accumulator would wrap: restart the averaging window
				time_sum[cls]  = (t > ACC_MASK) ? ACC_MASK : t;
				win_count[cls] = 1;
			end else begin
				time_sum[cls]  = acc + t;
				win_count[cls] = win_count[cls] + 1;
			end
		end
		q = (win_count[cls] == '0) ? '0 : time_sum[cls] / win_count[cls];
		res.recognized = 1'b1;
		res.op_count   = win_count[cls];
		res.all_time   = life_count[cls];
		res.avg        = (q > {{(CNT_W-AVG_W){1'b0}}, AVG_MAX}) ? AVG_MAX : q[AVG_W-1:0];
		return res;
	endfunction

	function automatic op_req_t mk_req(input logic rt, input logic [TAG_W-1:0] tag,
			input logic [TIME_W-1:0] el);
		op_req_t r;
		r.req_type = rt;
		r.tag      = tag;
		r.elapsed  = el;
		return r;
	endfunction

	// mostly known tags; full-range record times only on bind/unbind, other classes stay at or below 200000
	function automatic op_req_t rand_req();
		op_req_t r;
		int      pick;
		r.req_type = ($urandom_range(99) < 80) ? REQ_RECORD : REQ_QUERY;
		if ($urandom_range(99) < 75)
			r.tag = class_tag($urandom_range(N_CLS-1));
		else
			r.tag = TAG_W'($urandom_range(255));
		pick = $urandom_range(19);
		if (r.req_type == REQ_QUERY || tag_class(r.tag) == NO_CLASS)
			r.elapsed = $urandom;
		else if (pick == 0)
			r.elapsed = '0;
		else if (r.tag == TAG_BIND || r.tag == TAG_UNBIND) begin
			if (pick == 1)
				r.elapsed = '1;
			else if (pick < 5)
				r.elapsed = $urandom;
			else
				r.elapsed = $urandom_range(3000);
		end else if (pick == 1)
			r.elapsed = $urandom_range(200000);
		else
			r.elapsed = $urandom_range(3000);
		return r;
	endfunction

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || s_tvalid || expected_stats.size() != 0)
			@(posedge clk);
	endtask

	task automatic push_random(input int n);
		for (int i = 0; i < n; i++)
			pending_reqs.push_back(rand_req());
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_stats.push_back(stats_apply(sent_req));
				if (tag_class(sent_req.tag) == NO_CLASS)
					n_unknown++;
				if (sent_req.req_type == REQ_RECORD)
					n_records++;
				else
					n_queries++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
					drv_req  = pending_reqs.pop_front();
					sent_req = drv_req;
					s_tvalid <= 1'b1;
					s_tdata  <= {drv_req.elapsed, drv_req.tag};
					s_tuser  <= drv_req.req_type;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_results++;
				if (expected_stats.size() == 0) begin
					$error("unexpected result transaction: op_count %0d", m_tdata[63:0]);
					errors++;
				end else begin
					stats_result_t e;
					e = expected_stats.pop_front();
					if (m_tuser !== e.recognized) begin
						$error("recognized: expected %0d, got %0d", e.recognized, m_tuser);
						errors++;
					end
					if (m_tdata[63:0] !== e.op_count) begin
						$error("op_count: expected %0d, got %0d", e.op_count, m_tdata[63:0]);
						errors++;
					end
					if (m_tdata[127:64] !== e.all_time) begin
						$error("all_time_count: expected %0d, got %0d",
							e.all_time, m_tdata[127:64]);
						errors++;
					end
					if (m_tdata[143:128] !== e.avg) begin
						$error("avg_ms: expected %0d, got %0d", e.avg, m_tdata[143:128]);
						errors++;
					end
				end
			end
			m_tready <= ($urandom_range(99) >= idle_pct);
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= WATCHDOG) begin
			$display("tb: failure");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < N_CLS; i++) begin
			time_sum[i]   = '0;
			win_count[i]  = '0;
			life_count[i] = '0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty-class queries, zero and max times, unknown tags
		pending_reqs.push_back(mk_req(REQ_QUERY,  TAG_BIND,   32'd0));
		pending_reqs.push_back(mk_req(REQ_QUERY,  TAG_DELETE, 32'hFFFF_FFFF));
		for (int i = 0; i < N_CLS; i++)
			pending_reqs.push_back(mk_req(REQ_RECORD, class_tag(i), 32'd0));
		pending_reqs.push_back(mk_req(REQ_RECORD, TAG_BIND,   32'hFFFF_FFFF));
		pending_reqs.push_back(mk_req(REQ_QUERY,  TAG_BIND,   32'h0000_0000));
		pending_reqs.push_back(mk_req(REQ_RECORD, 8'h00,      32'hFFFF_FFFF));
		pending_reqs.push_back(mk_req(REQ_QUERY,  8'hFF,      32'h0000_0001));
		pending_reqs.push_back(mk_req(REQ_RECORD, 8'h61,      32'd5));
		pending_reqs.push_back(mk_req(REQ_RECORD, 8'h4B,      32'd5));
		pending_reqs.push_back(mk_req(REQ_RECORD, TAG_SEARCH, 32'd1));
		pending_reqs.push_back(mk_req(REQ_RECORD, TAG_SEARCH, 32'd1000));
		pending_reqs.push_back(mk_req(REQ_RECORD, TAG_SEARCH, 32'd262140));
		pending_reqs.push_back(mk_req(REQ_QUERY,  TAG_SEARCH, 32'hFFFF_FFFF));
		pending_reqs.push_back(mk_req(REQ_RECORD, TAG_MODIFY, 32'd65535));
		pending_reqs.push_back(mk_req(REQ_RECORD, TAG_ADD,    32'h8000_0000));
		pending_reqs.push_back(mk_req(REQ_QUERY,  TAG_ADD,    32'h7FFF_FFFF));
		wait_drained();

		push_random(700);
		// sender holds off until every result is back
		wait_drained();

		idle_pct = 0;
		push_random(300);
		wait_drained();

		idle_pct = IDLE_PCT;
		push_random(500);
		wait_drained();
		repeat (TAIL) @(posedge clk);

		$display("summary: %0d records, %0d queries (%0d with unknown tags), %0d results checked",
			n_records, n_queries, n_unknown, n_results);
		$display("summary: directed extremes, three random batches, one unthrottled");
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
